// ----- rtl/qubit_state_index_permute_core_assert.svh -----
// Assertion macros for the qubit state index permuter RTL, used by qsip_dp.
// Each macro expects clk and rst in scope of the including module.
`ifndef QUBIT_STATE_INDEX_PERMUTE_CORE_ASSERT_SVH
`define QUBIT_STATE_INDEX_PERMUTE_CORE_ASSERT_SVH

// Same-cycle implication.
`define QSIP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qsip: same-cycle check failed");

// Next-cycle implication.
`define QSIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qsip: next-cycle check failed");

`endif

// ----- rtl/qsip_pkg.sv -----
// Package for the qubit state index permuter: widths, register codes and
// the derived permutation record. No dependencies.
package qsip_pkg;

  localparam int MAX_QUBITS  = 16;
  localparam int MAX_MAP     = 3;
  localparam int MAP_REGS    = 3;
  localparam int MAP_LIMIT   = (MAX_MAP < MAP_REGS) ? MAX_MAP : MAP_REGS;
  localparam int POS_SPAN    = 16;
  localparam int POS_W       = 4;
  localparam int IDX_W       = 16;
  localparam int WIDTH_W     = 5;
  localparam int MSIZE_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAP_SIZE  = 2'd0,
    REG_MAP_BIT_A = 2'd1,
    REG_MAP_BIT_B = 2'd2,
    REG_MAP_BIT_C = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_SPAN-1:0][POS_W-1:0] perm;
    logic [POS_SPAN-1:0][POS_W-1:0] invp;
    logic [WIDTH_W-1:0]             width;
    logic                           err;
  } qsip_map_t;

endpackage

// ----- rtl/qsip_in_if.sv -----
// Input channel of the qubit state index permuter: valid/ready and one state index.
// Depends on qsip_pkg.
interface qsip_in_if
  import qsip_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] state_index;

  modport source (output valid, output state_index, input ready);
  modport sink (input valid, input state_index, output ready);
endinterface

// ----- rtl/qsip_out_if.sv -----
// Result channel of the qubit state index permuter: valid/ready and result fields.
// Depends on qsip_pkg.
interface qsip_out_if
  import qsip_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   forward_index;
  logic [IDX_W-1:0]   inverse_index;
  logic [WIDTH_W-1:0] width_bits;
  logic               map_error;
  logic               range_error;

  modport source (output valid, output forward_index, output inverse_index,
                  output width_bits, output map_error, output range_error,
                  input ready);
  modport sink (input valid, input forward_index, input inverse_index,
                input width_bits, input map_error, input range_error,
                output ready);
endinterface

// ----- rtl/qsip_cfg.sv -----
// Configuration registers and registered permutation derivation.
// Depends on qsip_pkg.
module qsip_cfg
  import qsip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output qsip_map_t              map
);

  logic [MSIZE_W-1:0]                map_size;
  logic [MAP_REGS-1:0][POS_W-1:0]    map_bit;
  logic [MSIZE_W-1:0]                m;
  logic [MAP_REGS-1:0]               used;
  logic [MAP_REGS-1:0]               high;
  logic                              dup;
  logic [WIDTH_W-1:0]                n;
  logic [POS_SPAN-1:0]               mapped;
  logic [POS_SPAN-1:0][POS_W-1:0]    src_of;
  logic [MAP_REGS-1:0][MSIZE_W-1:0]  src_rank;
  logic [POS_SPAN-1:0][MSIZE_W-1:0]  free_rank;
  logic [POS_SPAN-1:0][POS_W-1:0]    perm;
  logic [POS_SPAN-1:0][POS_W-1:0]    invp;
  qsip_map_t                         map_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= MSIZE_W'(1);
      for (int e = 0; e < MAP_REGS; e++) begin
        map_bit[e] <= POS_W'(e);
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAP_SIZE:  map_size   <= cfg_data[MSIZE_W-1:0];
        REG_MAP_BIT_A: map_bit[0] <= cfg_data[POS_W-1:0];
        REG_MAP_BIT_B: map_bit[1] <= cfg_data[POS_W-1:0];
        REG_MAP_BIT_C: map_bit[2] <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    m = map_size;
    if (m == '0) m = MSIZE_W'(1);
    if (int'(m) > MAP_LIMIT) m = MSIZE_W'(MAP_LIMIT);

    for (int e = 0; e < MAP_REGS; e++) begin
      used[e] = (e < int'(m));
      high[e] = used[e] && (map_bit[e] >= POS_W'(m));
    end

    dup = 1'b0;
    for (int e = 0; e < MAP_REGS; e++) begin
      for (int f = 0; f < MAP_REGS; f++) begin
        if (f > e && used[e] && used[f] && map_bit[e] == map_bit[f]) dup = 1'b1;
      end
    end

    n = WIDTH_W'(m);
    for (int e = 0; e < MAP_REGS; e++) begin
      if (used[e] && ({1'b0, map_bit[e]} + WIDTH_W'(1)) > n) begin
        n = {1'b0, map_bit[e]} + WIDTH_W'(1);
      end
    end

    for (int q = 0; q < POS_SPAN; q++) begin
      mapped[q] = 1'b0;
      src_of[q] = '0;
      for (int e = 0; e < MAP_REGS; e++) begin
        if (used[e] && map_bit[e] == POS_W'(q)) begin
          mapped[q] = 1'b1;
          src_of[q] = POS_W'(e);
        end
      end
    end

    // rank of displaced sources and of free low positions pair them in order
    for (int e = 0; e < MAP_REGS; e++) begin
      src_rank[e] = '0;
      for (int f = 0; f < MAP_REGS; f++) begin
        if (high[f] && map_bit[f] < map_bit[e]) src_rank[e] = src_rank[e] + MSIZE_W'(1);
      end
    end

    for (int q = 0; q < POS_SPAN; q++) begin
      free_rank[q] = '0;
      for (int r = 0; r < MAP_REGS; r++) begin
        if (r < q && r < int'(m) && !mapped[r]) free_rank[q] = free_rank[q] + MSIZE_W'(1);
      end
    end

    for (int q = 0; q < POS_SPAN; q++) begin
      perm[q] = POS_W'(q);
      if (mapped[q]) begin
        perm[q] = src_of[q];
      end else if (q < int'(m)) begin
        perm[q] = '0;
        for (int e = 0; e < MAP_REGS; e++) begin
          if (high[e] && src_rank[e] == free_rank[q]) perm[q] = map_bit[e];
        end
      end
    end

    for (int q = 0; q < POS_SPAN; q++) begin
      invp[q] = '0;
      for (int i = 0; i < POS_SPAN; i++) begin
        if (perm[i] == POS_W'(q)) invp[q] = POS_W'(i);
      end
    end

    map_next.perm  = perm;
    map_next.invp  = invp;
    map_next.width = n;
    map_next.err   = dup || (int'(n) > MAX_QUBITS);
  end

  always_ff @(posedge clk) begin
    map <= map_next;
  end

endmodule

// ----- rtl/qsip_dp.sv -----
// Index datapath: input register, bit crossbar and result register.
// Depends on qsip_pkg, qsip_in_if, qsip_out_if and the assertion macros.
`include "qubit_state_index_permute_core_assert.svh"

module qsip_dp
  import qsip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  qsip_map_t  map,
  qsip_in_if.sink    item,
  qsip_out_if.source result
);

  logic               s1_valid;
  logic [IDX_W-1:0]   s1_index;
  logic               out_valid;
  logic [IDX_W-1:0]   fwd;
  logic [IDX_W-1:0]   inv;
  logic [WIDTH_W-1:0] width;
  logic               merr;
  logic               rerr;
  logic [IDX_W-1:0]   fwd_next;
  logic [IDX_W-1:0]   inv_next;
  logic [WIDTH_W-1:0] width_next;
  logic               merr_next;
  logic               rerr_next;
  logic [IDX_W-1:0]   over;
  logic [IDX_W-1:0]   fwd_raw;
  logic [IDX_W-1:0]   inv_raw;
  logic               out_free;
  logic               s1_free;

  assign out_free   = !out_valid || result.ready;
  assign s1_free    = !s1_valid || out_free;
  assign item.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= item.valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item.valid) s1_index <= item.state_index;
    if (out_free && s1_valid) begin
      fwd   <= fwd_next;
      inv   <= inv_next;
      width <= width_next;
      merr  <= merr_next;
      rerr  <= rerr_next;
    end
  end

  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      over[b]    = (b >= int'(map.width));
      fwd_raw[b] = !over[b] && s1_index[map.invp[b]];
      inv_raw[b] = !over[b] && s1_index[map.perm[b]];
    end

    fwd_next   = fwd_raw;
    inv_next   = inv_raw;
    width_next = map.width;
    merr_next  = 1'b0;
    rerr_next  = |(s1_index & over);
    if (map.err) begin
      fwd_next   = '0;
      inv_next   = '0;
      width_next = '0;
      merr_next  = 1'b1;
      rerr_next  = 1'b0;
    end else if (rerr_next) begin
      fwd_next = '0;
      inv_next = '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.forward_index = fwd;
  assign result.inverse_index = inv;
  assign result.width_bits    = width;
  assign result.map_error     = merr;
  assign result.range_error   = rerr;

  `QSIP_ASSERT_IMPL(a_map_err_zero, result.valid && result.map_error, result.forward_index == '0 && result.inverse_index == '0 && result.width_bits == '0 && !result.range_error)
  `QSIP_ASSERT_IMPL(a_width_range, result.valid && !result.map_error, result.width_bits != '0 && int'(result.width_bits) <= MAX_QUBITS)
  `QSIP_ASSERT_IMPL(a_range_zero, result.valid && result.range_error, result.forward_index == '0 && result.inverse_index == '0)
  `QSIP_ASSERT_NEXT(a_stage_advance, s1_valid && out_free, out_valid)

endmodule

// ----- rtl/qubit_state_index_permute_core.sv -----
// Qubit state index permuter top level: configuration block and index datapath.
// Depends on qsip_pkg, qsip_in_if, qsip_out_if, qsip_cfg and qsip_dp.
//
// Takes one state index per cycle while the result side keeps accepting results,
// and returns one result transaction per index: each index passes through the
// input register and then through the bit crossbar into the result register.
// The permutation is derived from the map registers into a registered map after a
// configuration write, so write the map while no transaction is in flight; an
// index accepted from the edge after the write already sees the new map. A
// repeated map entry gives map_error with all other fields zero; an index at or
// above 2^width_bits gives range_error with both indices zero.
module qubit_state_index_permute_core
  import qsip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  qsip_in_if.sink                item,
  qsip_out_if.source             result
);

  qsip_map_t map;

  qsip_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .map       (map)
  );

  qsip_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .map    (map),
    .item   (item),
    .result (result)
  );

endmodule

// ----- sim/qubit_state_index_permute_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for qubit_state_index_permute_core: directed and random state indices
// under many qubit maps, every result checked against a behavioral permutation model.
// Depends on qsip_pkg, qsip_in_if, qsip_out_if and the core RTL.
module qubit_state_index_permute_core_test;
  import qsip_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 30;
  localparam int PHASE_ITEMS    = 50;

  typedef struct packed {
    logic [IDX_W-1:0]   forward_index;
    logic [IDX_W-1:0]   inverse_index;
    logic [WIDTH_W-1:0] width_bits;
    logic               map_error;
    logic               range_error;
  } index_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_MAP_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  qsip_in_if  item_ch ();
  qsip_out_if result_ch ();

  qubit_state_index_permute_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  logic [MSIZE_W-1:0] map_size_q;
  logic [POS_W-1:0]   map_bit_q [MAP_REGS];

  logic [IDX_W-1:0] index_queue [$];
  index_result_t    result_queue [$];
  index_result_t    want_result;
  index_result_t    got_result;

  int        gap_left;
  int        burst_left;
  bit        steady;
  logic [12:0] ready_pat;
  int        pat_age;
  int        mismatches;
  int        idle_cycles;

  always #10 clk = ~clk;

  function automatic index_result_t permute_index(logic [IDX_W-1:0] idx);
    int            m;
    int            n;
    int            top;
    int            slot;
    logic [POS_W-1:0] perm [POS_SPAN];
    bit            pos_taken [POS_SPAN];
    bit            src_taken [POS_SPAN];
    index_result_t r;
    r = '0;
    m = (map_size_q == 0) ? 1 : int'(map_size_q);
    if (m > MAP_LIMIT) m = MAP_LIMIT;
    for (int i = 0; i < m; i++)
      for (int j = i + 1; j < m; j++)
        if (map_bit_q[i] == map_bit_q[j]) begin
          r.map_error = 1'b1;
          return r;
        end
    top = 0;
    for (int i = 0; i < m; i++)
      if (int'(map_bit_q[i]) > top) top = int'(map_bit_q[i]);
    n = (m > top + 1) ? m : top + 1;
    if (n > MAX_QUBITS || n > POS_SPAN) begin
      r.map_error = 1'b1;
      return r;
    end
    for (int i = 0; i < POS_SPAN; i++) begin
      perm[i] = '0;
      pos_taken[i] = 1'b0;
      src_taken[i] = 1'b0;
    end
    for (int i = 0; i < m; i++) begin
      perm[map_bit_q[i]] = POS_W'(i);
      pos_taken[map_bit_q[i]] = 1'b1;
      src_taken[i] = 1'b1;
    end
    // unmapped positions above the map keep identity
    for (int i = m; i < n; i++)
      if (!pos_taken[i]) begin
        pos_taken[i] = 1'b1;
        src_taken[i] = 1'b1;
        perm[i] = POS_W'(i);
      end
    // leftover sources fill the lowest free positions
    slot = 0;
    for (int i = m; i < n; i++)
      if (!src_taken[i]) begin
        while (slot < n && pos_taken[slot]) slot++;
        if (slot >= n) break;
        perm[slot] = POS_W'(i);
        pos_taken[slot] = 1'b1;
        src_taken[i] = 1'b1;
      end
    r.width_bits = WIDTH_W'(n);
    if ((32'(idx) >> n) != 0) begin
      r.range_error = 1'b1;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      r.forward_index[perm[i]] = idx[i];
      r.inverse_index[i] = idx[perm[i]];
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int w);
    int mask;
    mask = (1 << w) - 1;
    case ($urandom_range(0, 9))
      0: return IDX_W'($urandom);
      1: return IDX_W'(mask);
      2: return IDX_W'(mask + 1);
      default: return IDX_W'($urandom & mask);
    endcase
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.state_index <= '0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        result_queue.insert(result_queue.size(), permute_index(item_ch.state_index));
        void'(index_queue.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = steady ? 0 : $urandom_range(0, 5);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (index_queue.size() > 0) begin
        item_ch.valid <= 1'b1;
        item_ch.state_index <= index_queue[0];
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: rotating stall pattern on ready, check each result transaction
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      ready_pat = 13'h1fff;
      pat_age = 0;
      mismatches = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got_result = '{result_ch.forward_index, result_ch.inverse_index,
                       result_ch.width_bits, result_ch.map_error, result_ch.range_error};
        if (result_queue.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: fwd=%h inv=%h width=%0d map_err=%b range_err=%b",
                     got_result.forward_index, got_result.inverse_index,
                     got_result.width_bits, got_result.map_error, got_result.range_error);
          mismatches++;
        end else begin
          want_result = result_queue.pop_front();
          if (got_result.forward_index !== want_result.forward_index ||
              got_result.inverse_index !== want_result.inverse_index ||
              got_result.width_bits !== want_result.width_bits ||
              got_result.map_error !== want_result.map_error ||
              got_result.range_error !== want_result.range_error) begin
            if (mismatches < 10)
              $display("mismatch: expected fwd=%h inv=%h width=%0d map_err=%b range_err=%b, got fwd=%h inv=%h width=%0d map_err=%b range_err=%b",
                       want_result.forward_index, want_result.inverse_index,
                       want_result.width_bits, want_result.map_error, want_result.range_error,
                       got_result.forward_index, got_result.inverse_index,
                       got_result.width_bits, got_result.map_error, got_result.range_error);
            mismatches++;
          end
        end
      end
      pat_age++;
      if (pat_age == 64) begin
        pat_age = 0;
        ready_pat = 13'($urandom) | 13'h1;
      end
      ready_pat = {ready_pat[0], ready_pat[12:1]};
      result_ch.ready <= steady | ready_pat[0];
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("qubit_state_index_permute_core_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (index_queue.size() > 0 || result_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      REG_MAP_SIZE:  map_size_q = v[MSIZE_W-1:0];
      REG_MAP_BIT_A: map_bit_q[0] = v[POS_W-1:0];
      REG_MAP_BIT_B: map_bit_q[1] = v[POS_W-1:0];
      REG_MAP_BIT_C: map_bit_q[2] = v[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_map(int size, int a, int b, int c);
    write_reg(REG_MAP_SIZE, CFG_DATA_W'(size));
    write_reg(REG_MAP_BIT_A, CFG_DATA_W'(a));
    write_reg(REG_MAP_BIT_B, CFG_DATA_W'(b));
    write_reg(REG_MAP_BIT_C, CFG_DATA_W'(c));
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int size;
    int a;
    int b;
    int c;
    int w;
    item_ch.valid = 1'b0;
    item_ch.state_index = '0;
    result_ch.ready = 1'b0;
    steady = 1'b0;
    map_size_q = MSIZE_W'(1);
    map_bit_q = '{POS_W'(0), POS_W'(1), POS_W'(2)};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset map: single qubit at bit zero, one-bit register
    index_queue = '{16'h0000, 16'h0001, 16'h0002, 16'hffff};
    drain();
    // full-width register, all three gate bits spread out
    program_map(3, 15, 0, 7);
    index_queue = '{16'h0000, 16'hffff, 16'haaaa, 16'h5555, 16'h8001, 16'h0080};
    drain();
    // repeated entry
    program_map(2, 5, 5, 9);
    index_queue = '{16'h0000, 16'hffff};
    drain();
    // map size zero acts as one
    program_map(0, 3, 3, 3);
    index_queue = '{16'h000f, 16'h0010, 16'h0009};
    drain();
    // repeat confined to an unused entry
    program_map(2, 1, 0, 1);
    index_queue = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004};
    drain();
    program_map(3, 2, 1, 0);
    index_queue = '{16'h0006, 16'h0008};
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = ($urandom_range(0, 5) == 0);
      size = $urandom_range(0, 3);
      case ($urandom_range(0, 7))
        0, 1: begin
          a = $urandom_range(0, 3);
          b = $urandom_range(0, 3);
          c = $urandom_range(0, 3);
        end
        2: begin
          a = $urandom_range(0, 15);
          b = a;
          c = $urandom_range(0, 15);
        end
        default: begin
          a = $urandom_range(0, 15);
          b = $urandom_range(0, 15);
          c = $urandom_range(0, 15);
        end
      endcase
      program_map(size, a, b, c);
      w = int'(permute_index('0).width_bits);
      repeat (PHASE_ITEMS) index_queue.insert(index_queue.size(), pick_index(w));
      drain();
    end

    if (mismatches == 0)
      $display("qubit_state_index_permute_core_test: done, clean");
    else
      $display("qubit_state_index_permute_core_test: done, errors");
    $finish;
  end

endmodule
